// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared shorthand for clocked assertions that are disabled during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The antecedent implies the consequent in the same cycle.
`define SPE_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spe_chk: same-cycle property violated");

// The antecedent implies the consequent in the following cycle.
`define SPE_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spe_chk: next-cycle property violated");

`endif

// ===== sv/spe_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sparse polynomial evaluator package
// Sizes, request codes, beat payload types and controller/datapath links.
// ---------------------------------------------------------------------------
package spe_pkg;

  localparam int MAX_TERMS = 64;
  localparam int IDX_W     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CNT_W     = $clog2(MAX_TERMS + 1);
  localparam int TC_W      = 7;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TERMS - 1);
  localparam logic [TC_W-1:0]  FULL_TC  = TC_W'(MAX_TERMS);

  // Request codes.
  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_ADD   = 2'd1;
  localparam logic [1:0] REQ_EVAL  = 2'd2;

  // Multiplier operand selection.
  localparam logic [1:0] MSEL_ACC_BASE  = 2'd0;
  localparam logic [1:0] MSEL_BASE_BASE = 2'd1;
  localparam logic [1:0] MSEL_ACC_COEF  = 2'd2;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [31:0]        power;
    logic signed [63:0] coef;
    logic signed [63:0] x;
  } spe_in_t;

  typedef struct packed {
    logic signed [63:0] value;
    logic               status;
    logic [TC_W-1:0]    term_count;
  } spe_out_t;

  typedef struct packed {
    logic       accept;
    logic       clear_all;
    logic       mem_rd;
    logic       scan;
    logic       idx_inc;
    logic       upd;
    logic       ins;
    logic       pow_init;
    logic       e_shift;
    logic       mul_start;
    logic [1:0] mul_sel;
    logic       acc_load;
    logic       base_load;
    logic       term_add;
    logic       load_out;
  } spe_cmd_t;

  typedef struct packed {
    logic match;
    logic slot_valid;
    logic last;
    logic e_zero;
    logic e_odd;
    logic e_hi_zero;
    logic mul_done;
  } spe_sts_t;

endpackage

// ===== sv/sparse_polynomial_evaluator_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sparse polynomial evaluator
// Holds up to MAX_TERMS (power, coefficient) terms and serves clear, add-term
// and evaluate requests with one result beat per request.
// ---------------------------------------------------------------------------
// Usage: each input beat carries one request; each request yields exactly one
// output beat with the value (evaluate only, else zero), a table-full flag and
// the number of stored terms. Both channels use valid/ready handshakes.
// The block works on one request at a time. Add term reads the table one
// slot at a time, looking for a matching power and the first free slot.
// Evaluate visits every slot; each stored term then runs the
// square-and-multiply loop on one shared multiplier.
// A finished result sits in the output register; the next request is taken
// while it waits, and a later result waits in its final state until the
// output register is free. After reset the table is empty, no result is
// pending and the block is ready for a request.
// ---------------------------------------------------------------------------
module sparse_polynomial_evaluator_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  spe_pkg::spe_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output spe_pkg::spe_out_t out_data
);

  // Command and status words between the controller and the datapath.
  spe_pkg::spe_cmd_t cmd;
  spe_pkg::spe_sts_t sts;

  // The controller decides the request path from the beat's request type;
  // all operands stay in the datapath.
  spe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_data.req_type),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath owns the term table, the power loop and the result register.
  spe_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

// ===== sv/spe_mul.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sequential 64-bit wrapping multiplier
// Forms the low 64 bits of a 64x64 product on one 32x32 multiplier in four
// steps and pulses done when the product register is loaded.
// ---------------------------------------------------------------------------
module spe_mul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] prod
);

  localparam logic [1:0] PH_LL  = 2'd0;
  localparam logic [1:0] PH_LH  = 2'd1;
  localparam logic [1:0] PH_HL  = 2'd2;
  localparam logic [1:0] PH_SUM = 2'd3;

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [63:0] a_r, b_r;
  logic [63:0] lo_r;
  logic [31:0] cross_r;
  logic [63:0] prod_r;
  logic [31:0] op_a, op_b;
  logic [63:0] m_full;

  always_comb begin
    case (phase_r)
      PH_LL: begin
        op_a = a_r[31:0];
        op_b = b_r[31:0];
      end
      PH_LH: begin
        op_a = a_r[31:0];
        op_b = b_r[63:32];
      end
      PH_HL: begin
        op_a = a_r[63:32];
        op_b = b_r[31:0];
      end
      default: begin
        op_a = a_r[31:0];
        op_b = b_r[31:0];
      end
    endcase
  end

  // Both operands are 32-bit values zero-extended to the product width.
  assign m_full = 64'(op_a) * 64'(op_b);

  always_comb begin
    busy_nxt  = busy_r;
    phase_nxt = phase_r;
    done_nxt  = 1'b0;
    if (start) begin
      busy_nxt  = 1'b1;
      phase_nxt = PH_LL;
    end else if (busy_r) begin
      phase_nxt = phase_r + 2'd1;
      if (phase_r == PH_SUM) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      phase_r <= PH_LL;
    end else begin
      busy_r  <= busy_nxt;
      done_r  <= done_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
    end
    if (busy_r) begin
      case (phase_r)
        PH_LL:   lo_r    <= m_full;
        PH_LH:   cross_r <= m_full[31:0];
        PH_HL:   cross_r <= cross_r + m_full[31:0];
        PH_SUM:  prod_r  <= lo_r + {cross_r, 32'd0};
        default: lo_r    <= lo_r;
      endcase
    end
  end

  assign done = done_r;
  assign prod = prod_r;

endmodule

// ===== sv/spe_dp.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sparse polynomial evaluator datapath
// Term table, slot scan index, power loop registers, multiplier and the
// result register, all driven by the controller's command word.
// ---------------------------------------------------------------------------
module spe_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  spe_pkg::spe_in_t   in_data,
  input  spe_pkg::spe_cmd_t  cmd,
  output spe_pkg::spe_sts_t  sts,
  output spe_pkg::spe_out_t  out_data
);

  // Term table: power and coefficient memories, valid bits in flops.
  logic [31:0] pw_mem [spe_pkg::MAX_TERMS];
  logic [63:0] cf_mem [spe_pkg::MAX_TERMS];

  logic [spe_pkg::MAX_TERMS-1:0] valid_r;
  logic [spe_pkg::CNT_W-1:0]     count_r;
  logic [spe_pkg::IDX_W-1:0]     idx_r;
  logic                          free_found_r;
  logic [spe_pkg::IDX_W-1:0]     free_idx_r;
  logic                          status_r;

  logic [31:0] pw_r;
  logic [63:0] cf_r, x_r;
  logic [31:0] pw_rd_r;
  logic [63:0] cf_rd_r;
  logic [63:0] acc_r, base_r, sum_r;
  logic [31:0] e_r;
  spe_pkg::spe_out_t out_r;

  logic [63:0]               upd_sum;
  logic                      upd_zero;
  logic                      cf_nz;
  logic                      ins_ok;
  logic                      wr_en;
  logic [spe_pkg::IDX_W-1:0] wr_addr;
  logic [63:0]               wr_cf;
  logic [63:0]               mul_a, mul_b, mul_prod;
  logic                      mul_done;

  assign upd_sum  = cf_rd_r + cf_r;
  assign upd_zero = (upd_sum == 64'd0);
  assign cf_nz    = (cf_r != 64'd0);
  assign ins_ok   = cmd.ins && cf_nz && free_found_r;
  assign wr_en    = cmd.upd || ins_ok;
  assign wr_addr  = cmd.upd ? idx_r : free_idx_r;
  assign wr_cf    = cmd.upd ? upd_sum : cf_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pw_mem[wr_addr] <= pw_r;
      cf_mem[wr_addr] <= wr_cf;
    end
    if (cmd.mem_rd) begin
      pw_rd_r <= pw_mem[idx_r];
      cf_rd_r <= cf_mem[idx_r];
    end
  end

  always_comb begin
    case (cmd.mul_sel)
      spe_pkg::MSEL_ACC_BASE: begin
        mul_a = acc_r;
        mul_b = base_r;
      end
      spe_pkg::MSEL_BASE_BASE: begin
        mul_a = base_r;
        mul_b = base_r;
      end
      spe_pkg::MSEL_ACC_COEF: begin
        mul_a = acc_r;
        mul_b = cf_rd_r;
      end
      default: begin
        mul_a = acc_r;
        mul_b = base_r;
      end
    endcase
  end

  spe_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  // Control state of the table.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      count_r      <= '0;
      idx_r        <= '0;
      free_found_r <= 1'b0;
      status_r     <= 1'b0;
    end else begin
      if (cmd.accept) begin
        idx_r        <= '0;
        free_found_r <= 1'b0;
        status_r     <= 1'b0;
      end
      if (cmd.idx_inc) begin
        idx_r <= idx_r + spe_pkg::IDX_W'(1);
      end
      if (cmd.clear_all) begin
        valid_r <= '0;
        count_r <= '0;
      end
      if (cmd.scan && !valid_r[idx_r] && !free_found_r) begin
        free_found_r <= 1'b1;
      end
      if (cmd.upd && upd_zero) begin
        valid_r[idx_r] <= 1'b0;
        count_r        <= count_r - spe_pkg::CNT_W'(1);
      end
      if (ins_ok) begin
        valid_r[free_idx_r] <= 1'b1;
        count_r             <= count_r + spe_pkg::CNT_W'(1);
      end
      if (cmd.ins && cf_nz && !free_found_r) begin
        status_r <= 1'b1;
      end
    end
  end

  // Operand and arithmetic registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pw_r  <= in_data.power;
      cf_r  <= in_data.coef;
      x_r   <= in_data.x;
      sum_r <= 64'd0;
    end
    if (cmd.scan && !valid_r[idx_r] && !free_found_r) begin
      free_idx_r <= idx_r;
    end
    if (cmd.pow_init) begin
      acc_r  <= 64'd1;
      base_r <= x_r;
      e_r    <= pw_rd_r;
    end
    if (cmd.acc_load) begin
      acc_r <= mul_prod;
    end
    if (cmd.base_load) begin
      base_r <= mul_prod;
    end
    if (cmd.e_shift) begin
      e_r <= {1'b0, e_r[31:1]};
    end
    if (cmd.term_add) begin
      sum_r <= sum_r + mul_prod;
    end
    if (cmd.load_out) begin
      out_r.value      <= $signed(sum_r);
      out_r.status     <= status_r;
      out_r.term_count <= spe_pkg::TC_W'(count_r);
    end
  end

  assign sts.match      = valid_r[idx_r] && (pw_rd_r == pw_r);
  assign sts.slot_valid = valid_r[idx_r];
  assign sts.last       = (idx_r == spe_pkg::LAST_IDX);
  assign sts.e_zero     = (e_r == 32'd0);
  assign sts.e_odd      = e_r[0];
  assign sts.e_hi_zero  = (e_r[31:1] == 31'd0);
  assign sts.mul_done   = mul_done;

  assign out_data = out_r;

endmodule

// ===== sv/spe_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sparse polynomial evaluator controller
// Sequences table scans, square-and-multiply steps and the result beat.
// ---------------------------------------------------------------------------
module spe_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_req,
  output logic              out_valid,
  input  logic              out_ready,
  input  spe_pkg::spe_sts_t sts,
  output spe_pkg::spe_cmd_t cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLR   = 4'd1;
  localparam logic [3:0] S_ARD   = 4'd2;
  localparam logic [3:0] S_ACHK  = 4'd3;
  localparam logic [3:0] S_AUPD  = 4'd4;
  localparam logic [3:0] S_AINS  = 4'd5;
  localparam logic [3:0] S_ERD   = 4'd6;
  localparam logic [3:0] S_ECHK  = 4'd7;
  localparam logic [3:0] S_ESTEP = 4'd8;
  localparam logic [3:0] S_EACC  = 4'd9;
  localparam logic [3:0] S_ESQ0  = 4'd10;
  localparam logic [3:0] S_ESQ   = 4'd11;
  localparam logic [3:0] S_ETERM = 4'd12;
  localparam logic [3:0] S_RESP  = 4'd13;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          case (in_req)
            spe_pkg::REQ_CLEAR: state_nxt = S_CLR;
            spe_pkg::REQ_ADD:   state_nxt = S_ARD;
            spe_pkg::REQ_EVAL:  state_nxt = S_ERD;
            default:            state_nxt = S_RESP;
          endcase
        end
      end
      S_CLR: begin
        cmd.clear_all = 1'b1;
        state_nxt     = S_RESP;
      end
      S_ARD: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = S_ACHK;
      end
      S_ACHK: begin
        if (sts.match) begin
          state_nxt = S_AUPD;
        end else begin
          cmd.scan = 1'b1;
          if (sts.last) begin
            state_nxt = S_AINS;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_ARD;
          end
        end
      end
      S_AUPD: begin
        cmd.upd   = 1'b1;
        state_nxt = S_RESP;
      end
      S_AINS: begin
        cmd.ins   = 1'b1;
        state_nxt = S_RESP;
      end
      S_ERD: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = S_ECHK;
      end
      S_ECHK: begin
        if (sts.slot_valid) begin
          cmd.pow_init = 1'b1;
          state_nxt    = S_ESTEP;
        end else if (sts.last) begin
          state_nxt = S_RESP;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_ERD;
        end
      end
      S_ESTEP: begin
        cmd.mul_start = 1'b1;
        if (sts.e_zero) begin
          cmd.mul_sel = spe_pkg::MSEL_ACC_COEF;
          state_nxt   = S_ETERM;
        end else if (sts.e_odd) begin
          cmd.mul_sel = spe_pkg::MSEL_ACC_BASE;
          state_nxt   = S_EACC;
        end else begin
          cmd.mul_start = 1'b0;
          state_nxt     = S_ESQ0;
        end
      end
      S_EACC: begin
        if (sts.mul_done) begin
          cmd.acc_load = 1'b1;
          state_nxt    = S_ESQ0;
        end
      end
      S_ESQ0: begin
        cmd.e_shift = 1'b1;
        if (sts.e_hi_zero) begin
          state_nxt = S_ESTEP;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = spe_pkg::MSEL_BASE_BASE;
          state_nxt     = S_ESQ;
        end
      end
      S_ESQ: begin
        if (sts.mul_done) begin
          cmd.base_load = 1'b1;
          state_nxt     = S_ESTEP;
        end
      end
      S_ETERM: begin
        if (sts.mul_done) begin
          cmd.term_add = 1'b1;
          if (sts.last) begin
            state_nxt = S_RESP;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_ERD;
          end
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== sv/spe_chk.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sparse polynomial evaluator port checker
// Watches the top-level ports and flags protocol or result inconsistencies.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module spe_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input spe_pkg::spe_in_t  in_data,
  input logic              out_valid,
  input logic              out_ready,
  input spe_pkg::spe_out_t out_data
);

  // A stalled result beat holds its payload.
  `SPE_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // Only one request is in work at a time.
  `SPE_ASSERT_NXT(a_one_at_a_time, in_valid && in_ready, !in_ready)

  // A dropped term means the table was full.
  `SPE_ASSERT_IMP(a_full_flag, out_valid && out_data.status, out_data.term_count == spe_pkg::FULL_TC)

  // A dropped term comes from an add request, which returns a zero value.
  `SPE_ASSERT_IMP(a_full_value, out_valid && out_data.status, out_data.value == 64'sd0)

endmodule

bind sparse_polynomial_evaluator_core spe_chk u_spe_chk (.*);

// ===== bench/tb_sparse_polynomial_evaluator_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sparse polynomial evaluator testbench
// Sends clear, add-term and evaluate beats to the core and keeps a shadow
// copy of the term table. Every accepted request is turned into the reply
// that the core must return, and each result beat is checked against the
// oldest reply still owed. Both handshakes idle at random in the first two
// phases; the second phase also fills the table to overflow.
// ---------------------------------------------------------------------------
module tb_sparse_polynomial_evaluator_core;

  // The unused request code; the core answers it with a zero value and leaves the table as it is.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // Shadow term table plus the queue of replies the core still owes.
  class poly_tracker;
    bit                  slot_used [spe_pkg::MAX_TERMS];
    logic [31:0]         slot_power [spe_pkg::MAX_TERMS];
    logic [63:0]         slot_coef [spe_pkg::MAX_TERMS];
    int unsigned         terms_held;
    spe_pkg::spe_out_t   due_replies [$];
    int unsigned         errors;

    // x^e modulo 2^64 by square-and-multiply.
    function logic [63:0] wrap_pow(logic [63:0] base, logic [31:0] e);
      logic [63:0] acc;
      acc = 64'd1;
      while (e != 32'd0) begin
        if (e[0]) acc = acc * base;
        e = e >> 1;
        if (e != 32'd0) base = base * base;
      end
      return acc;
    endfunction

    function int pick_live();
      int live [$];
      foreach (slot_used[i]) if (slot_used[i]) live.insert(live.size(), i);
      if (live.size() == 0) return -1;
      return live[$urandom_range(live.size() - 1)];
    endfunction

    // Applies one accepted request to the shadow table and queues its reply.
    function void note_request(spe_pkg::spe_in_t req);
      spe_pkg::spe_out_t reply;
      logic [63:0]       sum;
      int                hit;
      int                free_slot;
      reply = '0;
      case (req.req_type)
        spe_pkg::REQ_CLEAR: begin
          foreach (slot_used[i]) slot_used[i] = 1'b0;
          terms_held = 0;
        end
        spe_pkg::REQ_ADD: begin
          hit = -1;
          for (int i = 0; i < spe_pkg::MAX_TERMS; i++)
            if (hit < 0 && slot_used[i] && slot_power[i] == req.power) hit = i;
          if (hit >= 0) begin
            slot_coef[hit] = slot_coef[hit] + req.coef;
            if (slot_coef[hit] == 64'd0) begin
              slot_used[hit] = 1'b0;
              terms_held--;
            end
          end else if (req.coef != 64'd0) begin
            // A new power goes to the lowest free slot, or is dropped.
            free_slot = -1;
            for (int i = spe_pkg::MAX_TERMS - 1; i >= 0; i--)
              if (!slot_used[i]) free_slot = i;
            if (free_slot < 0) begin
              reply.status = 1'b1;
            end else begin
              slot_used[free_slot]  = 1'b1;
              slot_power[free_slot] = req.power;
              slot_coef[free_slot]  = req.coef;
              terms_held++;
            end
          end
        end
        spe_pkg::REQ_EVAL: begin
          sum = 64'd0;
          for (int i = 0; i < spe_pkg::MAX_TERMS; i++)
            if (slot_used[i]) sum = sum + slot_coef[i] * wrap_pow(req.x, slot_power[i]);
          reply.value = sum;
        end
        default: ;
      endcase
      reply.term_count = spe_pkg::TC_W'(terms_held);
      due_replies.insert(due_replies.size(), reply);
    endfunction

    function void check_result(spe_pkg::spe_out_t got);
      spe_pkg::spe_out_t want;
      if (due_replies.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: result beat with nothing owed: value=%h status=%0d terms=%0d",
                   $time, got.value, got.status, got.term_count);
        return;
      end
      want = due_replies.pop_front();
      if (got.value !== want.value || got.status !== want.status ||
          got.term_count !== want.term_count) begin
        errors++;
        if (errors <= 10)
          $display({"%0t: mismatch: expected value=%h status=%0d terms=%0d, ",
                    "got value=%h status=%0d terms=%0d"},
                   $time, want.value, want.status, want.term_count,
                   got.value, got.status, got.term_count);
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  spe_pkg::spe_in_t  in_data;
  logic              out_valid;
  logic              out_ready;
  spe_pkg::spe_out_t out_data;

  int unsigned in_idle_pct  = 27;
  int unsigned out_idle_pct = 65;
  int unsigned items_sent   = 0;
  poly_tracker shadow       = new;

  sparse_polynomial_evaluator_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Result side: ready changes at the falling edge, beats are taken at the rising edge.
  always @(negedge clk) out_ready <= ($urandom_range(99) >= out_idle_pct);

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) shadow.check_result(out_data);
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] extreme_value();
    case ($urandom_range(4))
      0: return 64'd0;
      1: return 64'd1;
      2: return '1;
      3: return 64'h7FFF_FFFF_FFFF_FFFF;
      default: return 64'h8000_0000_0000_0000;
    endcase
  endfunction

  function automatic logic [63:0] pick_x();
    case ($urandom_range(3))
      0: return 64'($urandom_range(8)) - 64'd4;
      1: return rand64();
      2: return extreme_value();
      default: return 64'($urandom_range(1000));
    endcase
  endfunction

  // Mostly small powers keep evaluation short; a few span the full field.
  function automatic logic [31:0] pick_power();
    if ($urandom_range(7) == 0) return $urandom;
    return 32'($urandom_range(40));
  endfunction

  function automatic logic [63:0] pick_coef();
    case ($urandom_range(3))
      0: return 64'($urandom_range(20)) - 64'd10;
      3: return extreme_value();
      default: return rand64();
    endcase
  endfunction

  // Presents one beat after a random gap and returns once it is accepted.
  // Valid stays high between back-to-back beats.
  task automatic issue(input logic [1:0] kind, input logic [31:0] pw,
                       input logic [63:0] cf, input logic [63:0] xv);
    spe_pkg::spe_in_t item;
    item.req_type = kind;
    item.power    = pw;
    item.coef     = cf;
    item.x        = xv;
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    shadow.note_request(item);
    if (kind != REQ_UNUSED) items_sent++;
  endtask

  // A well-formed stretch: optional clear, then adds that create, grow and
  // cancel terms, mixed with evaluations.
  task automatic build_round();
    int unsigned steps;
    int          k;
    if (shadow.terms_held > 12 || $urandom_range(2) == 0)
      issue(spe_pkg::REQ_CLEAR, $urandom, rand64(), rand64());
    steps = $urandom_range(10, 3);
    repeat (steps) begin
      k = shadow.pick_live();
      case ($urandom_range(9))
        0, 1, 2: issue(spe_pkg::REQ_ADD, pick_power(), pick_coef(), rand64());
        3, 4: issue(spe_pkg::REQ_ADD, (k >= 0) ? shadow.slot_power[k] : pick_power(),
                    pick_coef(), rand64());
        5: begin
          // Cancel a stored term so its slot is freed.
          if (k >= 0)
            issue(spe_pkg::REQ_ADD, shadow.slot_power[k], 64'd0 - shadow.slot_coef[k],
                  rand64());
          else
            issue(spe_pkg::REQ_ADD, pick_power(), 64'd0, rand64());
        end
        default: issue(spe_pkg::REQ_EVAL, $urandom, rand64(), pick_x());
      endcase
    end
  endtask

  // Fully random beats, the unused code included.
  task automatic noise_round();
    repeat ($urandom_range(6, 2))
      issue(2'($urandom_range(3)), $urandom, rand64(), rand64());
  endtask

  // Fills every slot, overflows it, then frees one slot and reuses it.
  task automatic fill_table();
    int unsigned n;
    int          k;
    issue(spe_pkg::REQ_CLEAR, $urandom, rand64(), rand64());
    n = 0;
    while (shadow.terms_held < spe_pkg::MAX_TERMS) begin
      issue(spe_pkg::REQ_ADD, (n % 8 == 7) ? $urandom : n, rand64() | 64'd1, rand64());
      n++;
    end
    issue(spe_pkg::REQ_EVAL, $urandom, rand64(), pick_x());
    issue(spe_pkg::REQ_ADD, 32'd100_000, rand64() | 64'd1, rand64());
    issue(spe_pkg::REQ_ADD, 32'hFFFF_FFF0, 64'd0, rand64());
    issue(spe_pkg::REQ_ADD, 32'hFFFF_FFF1, 64'h8000_0000_0000_0000, rand64());
    k = shadow.pick_live();
    issue(spe_pkg::REQ_ADD, shadow.slot_power[k], 64'd0 - shadow.slot_coef[k], rand64());
    issue(spe_pkg::REQ_ADD, 32'd100_001, rand64() | 64'd1, rand64());
    issue(spe_pkg::REQ_EVAL, $urandom, rand64(), pick_x());
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed opening: empty table, power zero at x = 0, field extremes,
    // wrap of the coefficient sum, cancellation and the unused code.
    issue(spe_pkg::REQ_EVAL, 32'd0, 64'd0, rand64());
    issue(REQ_UNUSED, $urandom, rand64(), rand64());
    issue(spe_pkg::REQ_ADD, 32'd0, 64'd0, 64'd0);
    issue(spe_pkg::REQ_ADD, 32'd0, 64'd5, 64'd0);
    issue(spe_pkg::REQ_EVAL, 32'd0, 64'd0, 64'd0);
    issue(spe_pkg::REQ_ADD, 32'hFFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, 64'd0);
    issue(spe_pkg::REQ_ADD, 32'd1, 64'h8000_0000_0000_0000, '1);
    issue(spe_pkg::REQ_EVAL, 32'hFFFF_FFFF, '1, '1);
    issue(spe_pkg::REQ_EVAL, 32'd0, 64'd0, 64'h7FFF_FFFF_FFFF_FFFF);
    issue(spe_pkg::REQ_EVAL, 32'd0, 64'd0, 64'h8000_0000_0000_0000);
    issue(spe_pkg::REQ_ADD, 32'd5, 64'd0, 64'd0);
    issue(spe_pkg::REQ_ADD, 32'd0, 64'hFFFF_FFFF_FFFF_FFFB, 64'd0);
    issue(spe_pkg::REQ_ADD, 32'hFFFF_FFFF, 64'd1, 64'd0);
    issue(spe_pkg::REQ_EVAL, 32'd0, 64'd0, 64'd3);
    issue(spe_pkg::REQ_ADD, 32'h8000_0000, '1, 64'd0);
    issue(spe_pkg::REQ_EVAL, 32'd0, 64'd0, 64'd2);
    issue(spe_pkg::REQ_EVAL, 32'd0, 64'd0, rand64());
    issue(REQ_UNUSED, $urandom, rand64(), rand64());
    issue(spe_pkg::REQ_CLEAR, $urandom, rand64(), rand64());
    issue(spe_pkg::REQ_EVAL, $urandom, rand64(), 64'd7);

    // Random part in three idling phases.
    for (int phase = 0; phase < 3; phase++) begin
      in_idle_pct  = (phase == 0) ? 27 : (phase == 1) ? 65 : 0;
      out_idle_pct = (phase == 0) ? 65 : (phase == 1) ? 27 : 0;
      if (phase == 1) fill_table();
      while (items_sent < 20 + (phase + 1) * 90) begin
        if ($urandom_range(3) == 0) noise_round();
        else build_round();
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (shadow.due_replies.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (shadow.errors == 0 && shadow.due_replies.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/spe_pkg.sv
sv/spe_mul.sv
sv/spe_dp.sv
sv/spe_ctrl.sv
sv/sparse_polynomial_evaluator_core.sv
sv/spe_chk.sv
bench/tb_sparse_polynomial_evaluator_core.sv
